[rtl/cgci_pkg.sv]
`timescale 1ns / 1ps
// Package for the gap-compressed identity block: default sizes, CIGAR
// character codes and the command/status structs between controller and datapath.
// No dependencies.
package cgci_pkg;

	// default sizes, handed to the top level parameters
	localparam int COUNT_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// fixed port field widths
	localparam int CHAR_W  = 8;
	localparam int TOTAL_W = 32;
	localparam int IDENT_W = 17;

	// CIGAR character codes
	localparam logic [CHAR_W-1:0] CH_EQ  = 8'h3D; // '='
	localparam logic [CHAR_W-1:0] CH_X   = 8'h58; // 'X'
	localparam logic [CHAR_W-1:0] CH_D   = 8'h44; // 'D'
	localparam logic [CHAR_W-1:0] CH_I   = 8'h49; // 'I'
	localparam logic [CHAR_W-1:0] CH_0   = 8'h30; // '0'
	localparam logic [CHAR_W-1:0] CH_9   = 8'h39; // '9'
	localparam int                RADIX  = 10;

	// controller to datapath
	typedef struct packed {
		logic accept;    // input word taken this cycle
		logic prep;      // load divider from final counts
		logic iter;      // one restoring divide step
		logic load_out;  // capture result, clear counts
	} cgci_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_iter; // divider is on its final step
		logic out_free;  // output register can take a word
	} cgci_sts_t;

endpackage

[rtl/cgci_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the gap-compressed identity block: sequences character
// intake, the divide and the result hand-off. Depends on cgci_pkg.
module cgci_ctrl
	import cgci_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last_char,
	output logic      in_stall,
	input  cgci_sts_t sts,
	output cgci_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (in_valid && last_char) state_q <= ST_PREP;
				end
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.last_iter) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == ST_RUN) && in_valid;
		cmd.prep     = (state_q == ST_PREP);
		cmd.iter     = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_DONE) && sts.out_free;
	end

	// characters are only taken while streaming
	assign in_stall = (state_q != ST_RUN);

endmodule

[rtl/cgci_dp.sv]
`timescale 1ns / 1ps
// Datapath for the gap-compressed identity block: run length and saturating
// counters, bit-serial restoring divider and output register. Depends on cgci_pkg.
module cgci_dp
	import cgci_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CHAR_W-1:0]  char_code,
	input  cgci_cmd_t          cmd,
	output cgci_sts_t          sts,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDENT_W-1:0] identity_q16,
	output logic [TOTAL_W-1:0] match_total,
	output logic [TOTAL_W-1:0] mismatch_total,
	output logic [TOTAL_W-1:0] gap_run_total,
	output logic               empty_denominator,
	output logic               overflowed
);

	localparam int CB   = COUNT_BITS;
	localparam int DW   = COUNT_BITS + 2;              // denominator width
	localparam int QW   = FRAC_BITS + 1;               // quotient incl. integer bit
	localparam int EW   = (QW > IDENT_W) ? QW : IDENT_W;
	localparam int TW   = (CB > TOTAL_W) ? CB : TOTAL_W;
	localparam int CNTW = $clog2(FRAC_BITS);
	localparam logic [CB-1:0] CMAX = {CB{1'b1}};

	logic [CB-1:0]        run_q, match_q, mism_q, gap_q;
	logic                 sat_q;
	logic [DW-1:0]        den_q, rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 full_q, empty_q;
	logic                 out_valid_q;

	// digit step: run*10 + d, by shift and add
	logic [CB+3:0] run_x10;
	logic          is_digit;
	always_comb begin
		run_x10  = ({4'd0, run_q} << 3) + ({4'd0, run_q} << 1)
			+ (CB+4)'(char_code - CH_0);
		is_digit = char_code inside {[CH_0:CH_9]};
	end

	// saturating adds
	logic [CB:0] match_sum, mism_sum, gap_sum;
	assign match_sum = {1'b0, match_q} + {1'b0, run_q};
	assign mism_sum  = {1'b0, mism_q} + {1'b0, run_q};
	assign gap_sum   = {1'b0, gap_q} + (CB+1)'(1);

	// divider step
	logic [DW:0] rem_x2;
	logic        ge;
	assign rem_x2 = {rem_q, 1'b0};
	assign ge     = (rem_x2 >= {1'b0, den_q});

	// count state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			match_q <= '0;
			mism_q  <= '0;
			gap_q   <= '0;
			sat_q   <= 1'b0;
		end else if (cmd.load_out) begin
			run_q   <= '0;
			match_q <= '0;
			mism_q  <= '0;
			gap_q   <= '0;
			sat_q   <= 1'b0;
		end else if (cmd.accept) begin
			if (is_digit) begin
				if (run_x10 > (CB+4)'(CMAX)) begin
					run_q <= CMAX;
					sat_q <= 1'b1;
				end else begin
					run_q <= run_x10[CB-1:0];
				end
			end else begin
				run_q <= '0;
				case (char_code)
					CH_EQ: begin
						match_q <= match_sum[CB] ? CMAX : match_sum[CB-1:0];
						if (match_sum[CB]) sat_q <= 1'b1;
					end
					CH_X: begin
						mism_q <= mism_sum[CB] ? CMAX : mism_sum[CB-1:0];
						if (mism_sum[CB]) sat_q <= 1'b1;
					end
					CH_D, CH_I: begin
						gap_q <= gap_sum[CB] ? CMAX : gap_sum[CB-1:0];
						if (gap_sum[CB]) sat_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// divider: load, then one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			den_q   <= DW'(match_q) + DW'(mism_q) + DW'(gap_q);
			rem_q   <= DW'(match_q);
			quo_q   <= '0;
			cnt_q   <= '0;
			empty_q <= (match_q == '0) && (mism_q == '0) && (gap_q == '0);
			full_q  <= (mism_q == '0) && (gap_q == '0);
		end else if (cmd.iter) begin
			rem_q <= ge ? DW'(rem_x2 - {1'b0, den_q}) : rem_x2[DW-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], ge};
			cnt_q <= cnt_q + CNTW'(1);
		end
	end

	assign sts.last_iter = (cnt_q == CNTW'(FRAC_BITS - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	// result value before masking
	logic [QW-1:0] ident_full;
	logic [EW-1:0] ident_ext;
	logic [TW-1:0] m_ext, x_ext, g_ext;
	always_comb begin
		if (empty_q)     ident_full = '0;
		else if (full_q) ident_full = QW'(1) << FRAC_BITS;
		else             ident_full = {1'b0, quo_q};
		ident_ext = EW'(ident_full);
		m_ext     = TW'(match_q);
		x_ext     = TW'(mism_q);
		g_ext     = TW'(gap_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			identity_q16      <= ident_ext[IDENT_W-1:0];
			match_total       <= m_ext[TOTAL_W-1:0];
			mismatch_total    <= x_ext[TOTAL_W-1:0];
			gap_run_total     <= g_ext[TOTAL_W-1:0];
			empty_denominator <= empty_q;
			overflowed        <= sat_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/cigar_gap_compressed_identity_top.sv]
`timescale 1ns / 1ps
// Gap-compressed identity of an extended CIGAR string, top level.
// Usage:
//   Input channel (in_valid / in_stall): one CIGAR character per word,
//   char_code plus last_char marking the final character of the string.
//   Characters are taken one per cycle while the string streams in.
//   Output channel (out_valid / out_stall): one result word per string with
//   identity_q16 = match/(match+mismatch+gaps) in fixed point, the three
//   totals, empty_denominator and overflowed.
// Sequencing:
//   After the last character is taken, the input stalls while the
//   denominator is formed, the bit-serial restoring divider runs and
//   the output register is loaded. All other characters are taken
//   without a stall.
// Stall: the output register holds its word while out_stall is high; the
//   next string streams in meanwhile, and its final load waits for the
//   output register to free up.
// Reset: arst_n clears all counts, the saturation flag and out_valid.
// Depends on cgci_pkg, cgci_ctrl and cgci_dp.
module cigar_gap_compressed_identity_top
	import cgci_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDENT_W-1:0] identity_q16,
	output logic [TOTAL_W-1:0] match_total,
	output logic [TOTAL_W-1:0] mismatch_total,
	output logic [TOTAL_W-1:0] gap_run_total,
	output logic               empty_denominator,
	output logic               overflowed
);

	cgci_cmd_t cmd;
	cgci_sts_t sts;

	// sequencing
	cgci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_char (last_char),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// counters, divider, output register
	cgci_dp #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.char_code         (char_code),
		.cmd               (cmd),
		.sts               (sts),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.identity_q16      (identity_q16),
		.match_total       (match_total),
		.mismatch_total    (mismatch_total),
		.gap_run_total     (gap_run_total),
		.empty_denominator (empty_denominator),
		.overflowed        (overflowed)
	);

endmodule

[rtl/cgci_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the gap-compressed identity block, bound to the top
// level. Depends on cgci_pkg and cigar_gap_compressed_identity_top.
module cgci_checker
	import cgci_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               last_char,
	input logic               out_valid,
	input logic               out_stall,
	input logic [IDENT_W-1:0] identity_q16,
	input logic [TOTAL_W-1:0] match_total,
	input logic [TOTAL_W-1:0] mismatch_total,
	input logic [TOTAL_W-1:0] gap_run_total,
	input logic               empty_denominator,
	input logic               overflowed
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(identity_q16)
			&& $stable(match_total) && $stable(mismatch_total)
			&& $stable(gap_run_total) && $stable(empty_denominator)
			&& $stable(overflowed))
		else $error("stalled result word changed");

	// the final character starts the divide, so the input stalls next cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_char |=> in_stall)
		else $error("input not stalled after final character");

	// empty denominator reports zero identity
	a_empty_ident: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_denominator |-> identity_q16 == '0)
		else $error("nonzero identity with empty denominator");

	// empty denominator means all totals are zero
	a_empty_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_denominator |->
			match_total == '0 && mismatch_total == '0 && gap_run_total == '0)
		else $error("nonzero totals with empty denominator");

endmodule

bind cigar_gap_compressed_identity_top cgci_checker u_cgci_checker (.*);

[dv/cigar_gap_compressed_identity_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for cigar_gap_compressed_identity_top: streams directed and random
// CIGAR strings and checks every result word against a scoreboard that recomputes the totals.
// Depends on cgci_pkg and the block's RTL.
module cigar_gap_compressed_identity_top_tb;
	import cgci_pkg::*;

	localparam logic [63:0] CNT_MAX      = (64'd1 << COUNT_BITS_DEF) - 64'd1;
	localparam int          SETTLE_CYC   = FRAC_BITS_DEF + 8;
	localparam int          PHASE_CHARS  = 200;
	localparam string       OTHER_OPS    = "MNSHP";
	localparam string       DIGITS       = "0123456789";

	typedef struct {
		logic [IDENT_W-1:0] identity;
		logic [TOTAL_W-1:0] match_tot;
		logic [TOTAL_W-1:0] mismatch_tot;
		logic [TOTAL_W-1:0] gap_tot;
		logic               empty_den;
		logic               ovf;
	} identity_report_t;

	// running totals of the string in flight, and the reports still owed by the block
	class identity_scoreboard;
		logic [63:0]      run_len;
		logic [63:0]      n_match;
		logic [63:0]      n_mismatch;
		logic [63:0]      n_gap;
		bit               sat;
		identity_report_t pending_reports[$];
		int               errors;

		function new();
			clear_counts();
			errors = 0;
		endfunction

		function void clear_counts();
			run_len    = '0;
			n_match    = '0;
			n_mismatch = '0;
			n_gap      = '0;
			sat        = 1'b0;
		endfunction

		function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
			logic [63:0] s;
			s = a + b;
			if (s > CNT_MAX) begin
				sat = 1'b1;
				return CNT_MAX;
			end
			return s;
		endfunction

		function int outstanding();
			return pending_reports.size();
		endfunction

		// one accepted input word
		function void note_char(logic [CHAR_W-1:0] c, logic fin);
			identity_report_t rep;
			logic [63:0]      den;
			if (c >= CH_0 && c <= CH_9) begin
				run_len = run_len * 64'(RADIX) + 64'(c - CH_0);
				if (run_len > CNT_MAX) begin
					sat     = 1'b1;
					run_len = CNT_MAX;
				end
			end else begin
				if (c == CH_EQ)
					n_match = add_sat(n_match, run_len);
				else if (c == CH_X)
					n_mismatch = add_sat(n_mismatch, run_len);
				else if (c == CH_D || c == CH_I)
					n_gap = add_sat(n_gap, 64'd1);
				run_len = '0;
			end
			if (!fin)
				return;

			// end of string: ratio by plain floor division
			den           = n_match + n_mismatch + n_gap;
			rep.empty_den = (den == 0);
			if (den == 0)
				rep.identity = '0;
			else if (n_match >= den)
				rep.identity = IDENT_W'(64'd1 << FRAC_BITS_DEF);
			else
				rep.identity = IDENT_W'((n_match << FRAC_BITS_DEF) / den);
			rep.match_tot    = n_match[TOTAL_W-1:0];
			rep.mismatch_tot = n_mismatch[TOTAL_W-1:0];
			rep.gap_tot      = n_gap[TOTAL_W-1:0];
			rep.ovf          = sat;
			pending_reports.push_back(rep);
			clear_counts();
		endfunction

		function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (act_v !== exp_v) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
			end
		endfunction

		// one accepted result word
		function void check_report(identity_report_t got);
			identity_report_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word: expected none actual identity %0h",
					$time, got.identity);
				return;
			end
			want = pending_reports.pop_front();
			cmp_field("identity_q16", want.identity, got.identity);
			cmp_field("match_total", want.match_tot, got.match_tot);
			cmp_field("mismatch_total", want.mismatch_tot, got.mismatch_tot);
			cmp_field("gap_run_total", want.gap_tot, got.gap_tot);
			cmp_field("empty_denominator", want.empty_den, got.empty_den);
			cmp_field("overflowed", want.ovf, got.ovf);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [CHAR_W-1:0]  char_code;
	logic               last_char;
	logic               out_valid;
	logic               out_stall;
	logic [IDENT_W-1:0] identity_q16;
	logic [TOTAL_W-1:0] match_total;
	logic [TOTAL_W-1:0] mismatch_total;
	logic [TOTAL_W-1:0] gap_run_total;
	logic               empty_denominator;
	logic               overflowed;

	identity_scoreboard sb = new();
	int                 send_idle_pct = 0;
	int                 stall_pct     = 0;
	int                 chars_sent    = 0;

	cigar_gap_compressed_identity_top u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.char_code         (char_code),
		.last_char         (last_char),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.identity_q16      (identity_q16),
		.match_total       (match_total),
		.mismatch_total    (mismatch_total),
		.gap_run_total     (gap_run_total),
		.empty_denominator (empty_denominator),
		.overflowed        (overflowed)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	// watch both channels
	always @(posedge clk) begin
		identity_report_t got;
		if (arst_n) begin
			if (in_valid === 1'b1 && in_stall === 1'b0)
				sb.note_char(char_code, last_char);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got.identity     = identity_q16;
				got.match_tot    = match_total;
				got.mismatch_tot = mismatch_total;
				got.gap_tot      = gap_run_total;
				got.empty_den    = empty_denominator;
				got.ovf          = overflowed;
				sb.check_report(got);
			end
		end
	end

	// hard stop
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// one input word, with random idle cycles ahead of it
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= fin;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// random string: mostly well-formed runs, some stray bytes and trailing digits
	task automatic send_random_string();
		logic [CHAR_W-1:0] txt[$];
		int                n_ops;
		int                nd;
		int                r;
		bit                heavy;
		heavy = ($urandom_range(19) == 0);
		n_ops = $urandom_range(1, 8);
		for (int k = 0; k < n_ops; k++) begin
			if ($urandom_range(99) < 10) begin
				txt.push_back(CHAR_W'($urandom_range(255)));
			end else begin
				r = $urandom_range(99);
				if (heavy)
					nd = 10;
				else if (r < 8)
					nd = 0;
				else if (r < 96)
					nd = $urandom_range(1, 3);
				else
					nd = $urandom_range(10, 11);
				for (int d = 0; d < nd; d++) begin
					if (heavy && d == 0)
						txt.push_back(DIGITS[$urandom_range(4, 9)]);
					else
						txt.push_back(DIGITS[$urandom_range(9)]);
				end
				case ($urandom_range(9))
					0, 1, 2: txt.push_back(CH_EQ);
					3, 4:    txt.push_back(CH_X);
					5, 6:    txt.push_back(CH_D);
					7, 8:    txt.push_back(CH_I);
					default: txt.push_back(OTHER_OPS[$urandom_range(OTHER_OPS.len() - 1)]);
				endcase
			end
		end
		if ($urandom_range(9) == 0)
			txt.push_back(DIGITS[$urandom_range(9)]);
		for (int i = 0; i < txt.size(); i++)
			send_char(txt[i], i == txt.size() - 1);
	endtask

	// hold the sender until every result word is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int target;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		char_code = '0;
		last_char = 1'b0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty denominator, lone gap, mixed runs, saturation,
		// trailing digits, byte extremes
		send_text("=");
		send_text("D");
		send_text("3=1X2I");
		send_text("42949672950=");
		send_text("5=7");
		send_text("4294967295=9=");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		drain();

		// random phases: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 76; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 76; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			target = chars_sent + PHASE_CHARS;
			while (chars_sent < target)
				send_random_string();
			drain();
		end

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
